// File: hw/rtl/typed_running_min_max_core_assert.svh
`ifndef TYPED_RUNNING_MIN_MAX_CORE_ASSERT_SVH
`define TYPED_RUNNING_MIN_MAX_CORE_ASSERT_SVH
// Concurrent check helpers, sampled on the rising clock, off during reset
`define TRMM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TRMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hw/rtl/trmm_pkg.sv
package trmm_pkg;
    localparam int unsigned ValueBits = 64;
    localparam int unsigned CountBits = 16;
    localparam int unsigned TypeBits  = 4;
    localparam int unsigned CfgIdxBits = 1;
    localparam int unsigned CfgDataBits = 4;

    localparam logic [CfgIdxBits-1:0] CFG_VALUE_TYPE = 1'b0;
    localparam logic [CfgIdxBits-1:0] CFG_FIND_MIN   = 1'b1;

    localparam logic [TypeBits-1:0] TYPE_I8  = 4'd0;
    localparam logic [TypeBits-1:0] TYPE_I16 = 4'd1;
    localparam logic [TypeBits-1:0] TYPE_I32 = 4'd2;
    localparam logic [TypeBits-1:0] TYPE_I64 = 4'd3;
    localparam logic [TypeBits-1:0] TYPE_U8  = 4'd4;
    localparam logic [TypeBits-1:0] TYPE_U16 = 4'd5;
    localparam logic [TypeBits-1:0] TYPE_U32 = 4'd6;
    localparam logic [TypeBits-1:0] TYPE_U64 = 4'd7;
    localparam logic [TypeBits-1:0] TYPE_F32 = 4'd8;
    localparam logic [TypeBits-1:0] TYPE_F64 = 4'd9;

    typedef logic [ValueBits-1:0] t_value;

    // Mask of the bits a type occupies
    function automatic t_value type_mask(input logic [TypeBits-1:0] t);
        t_value m;
        unique case (t)
            TYPE_I8, TYPE_U8:             m = 64'h0000_0000_0000_00FF;
            TYPE_I16, TYPE_U16:           m = 64'h0000_0000_0000_FFFF;
            TYPE_I32, TYPE_U32, TYPE_F32: m = 64'h0000_0000_FFFF_FFFF;
            default:                      m = '1;
        endcase
        return m;
    endfunction
endpackage

// File: hw/rtl/trmm_compare.sv
module trmm_compare (
    input  logic [trmm_pkg::TypeBits-1:0] i_type,
    input  trmm_pkg::t_value              i_a,
    input  trmm_pkg::t_value              i_b,
    output logic                          o_lt,
    output logic                          o_gt
);
    import trmm_pkg::*;

    logic        sgn;
    logic [63:0] xa;
    logic [63:0] xb;
    logic        flt;
    logic        dbl;
    logic        a_nan;
    logic        b_nan;
    logic        a_neg;
    logic        b_neg;
    logic        both_zero;
    logic [62:0] ma;
    logic [62:0] mb;
    logic        mag_lt;
    logic        mag_gt;

    always_comb begin
        sgn = (i_type == TYPE_I8) || (i_type == TYPE_I16) ||
              (i_type == TYPE_I32) || (i_type == TYPE_I64);
        flt = (i_type == TYPE_F32);
        dbl = (i_type == TYPE_F64);
        // Sign-extend narrow integers, flip the sign for signed order
        unique case (i_type)
            TYPE_I8:  begin xa = {{56{i_a[7]}},  i_a[7:0]};  xb = {{56{i_b[7]}},  i_b[7:0]};  end
            TYPE_I16: begin xa = {{48{i_a[15]}}, i_a[15:0]}; xb = {{48{i_b[15]}}, i_b[15:0]}; end
            TYPE_I32: begin xa = {{32{i_a[31]}}, i_a[31:0]}; xb = {{32{i_b[31]}}, i_b[31:0]}; end
            default:  begin xa = i_a & type_mask(i_type);    xb = i_b & type_mask(i_type);    end
        endcase
        if (sgn) begin
            xa[63] = ~xa[63];
            xb[63] = ~xb[63];
        end
        // Float fields: sign and magnitude
        if (flt) begin
            a_neg = i_a[31];
            b_neg = i_b[31];
            ma = {32'd0, i_a[30:0]};
            mb = {32'd0, i_b[30:0]};
            a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != '0);
            b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != '0);
        end else begin
            a_neg = i_a[63];
            b_neg = i_b[63];
            ma = i_a[62:0];
            mb = i_b[62:0];
            a_nan = (i_a[62:52] == 11'h7FF) && (i_a[51:0] != '0);
            b_nan = (i_b[62:52] == 11'h7FF) && (i_b[51:0] != '0);
        end
        mag_lt = ma < mb;
        mag_gt = ma > mb;
        both_zero = (ma == '0) && (mb == '0);
        if (flt || dbl) begin
            if (a_nan || b_nan || both_zero) begin
                o_lt = 1'b0;
                o_gt = 1'b0;
            end else begin
                priority if (a_neg && !b_neg) begin
                    o_lt = 1'b1; o_gt = 1'b0;
                end else if (!a_neg && b_neg) begin
                    o_lt = 1'b0; o_gt = 1'b1;
                end else if (a_neg) begin
                    o_lt = mag_gt; o_gt = mag_lt;
                end else begin
                    o_lt = mag_lt; o_gt = mag_gt;
                end
            end
        end else begin
            o_lt = xa < xb;
            o_gt = xa > xb;
        end
    end
endmodule

// File: hw/rtl/typed_running_min_max_core.sv
// Running min/max aggregate over typed column values. One beat is accepted
// every cycle while no result waits unaccepted: the registered input beat
// is compared against the extreme register and the group state updated, and a
// result register holds the group result (sent on the beat with tlast) while the
// next group already streams in. The result becomes valid once the tlast beat
// has passed the input stage and the result register; while a result waits
// unaccepted, s_axis_tready is low and the whole pipeline holds.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
module typed_running_min_max_core #(
    parameter int unsigned ROW_INDEX_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [trmm_pkg::CfgIdxBits-1:0]    i_cfg_idx,
    input  logic [trmm_pkg::CfgDataBits-1:0]   i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // value_bits[63:0], is_null[64], row_index[80:65], pad
    input  logic [87:0]                        s_axis_tdata,
    // command
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // extreme_value[63:0], extreme_row[79:64], has_value[80], value_count[96:81], pad
    output logic [103:0]                       m_axis_tdata
);
    import trmm_pkg::*;

    // row_index is a 16-bit field, so at most 16 bits are kept
    localparam int unsigned RowBits = (ROW_INDEX_BITS < 16) ? ROW_INDEX_BITS : 16;

    logic [TypeBits-1:0]       r_type;
    logic                      r_min;
    // input stage
    logic                      r_iv;
    t_value                    r_ibits;
    logic                      r_inull;
    logic [RowBits-1:0]        r_irow;
    logic                      r_ilast;
    // group state
    t_value                    r_ext, n_ext;
    logic [RowBits-1:0]        r_pos, n_pos;
    logic                      r_seen, n_seen;
    logic [CountBits-1:0]      r_cnt, n_cnt;
    // result stage
    logic                      r_ov;
    logic [103:0]              r_odata;
    logic                      lt;
    logic                      gt;
    logic                      adv;
    t_value                    bits;

    assign adv = !r_ov || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_odata;
    assign bits = r_ibits & type_mask(r_type);

    trmm_compare u_cmp (
        .i_type (r_type),
        .i_a    (bits),
        .i_b    (r_ext),
        .o_lt   (lt),
        .o_gt   (gt)
    );

    // Fold the registered beat into the group state
    always_comb begin
        n_ext  = r_ext;
        n_pos  = r_pos;
        n_seen = r_seen;
        n_cnt  = r_cnt;
        if (r_iv && !r_inull) begin
            if (!r_seen || (r_min ? lt : gt)) begin
                n_ext = bits;
                n_pos = r_irow;
            end
            n_seen = 1'b1;
            if (r_cnt != '1) n_cnt = r_cnt + 1'b1;
        end
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= TYPE_I64;
            r_min  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VALUE_TYPE: r_type <= i_cfg_data;
                CFG_FIND_MIN:   r_min  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance input stage, group state and result stage together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv   <= 1'b0;
            r_ov   <= 1'b0;
            r_ext  <= '0;
            r_pos  <= '0;
            r_seen <= 1'b0;
            r_cnt  <= '0;
        end else if (adv) begin
            r_iv <= s_axis_tvalid;
            r_ov <= r_iv && r_ilast;
            if (r_iv && r_ilast) begin
                r_ext  <= '0;
                r_pos  <= '0;
                r_seen <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_ext  <= n_ext;
                r_pos  <= n_pos;
                r_seen <= n_seen;
                r_cnt  <= n_cnt;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ibits <= s_axis_tdata[63:0];
            r_inull <= s_axis_tdata[64];
            r_irow  <= s_axis_tdata[65 +: RowBits];
            r_ilast <= s_axis_tlast;
            r_odata <= {7'd0, n_cnt, n_seen, 16'(n_pos), n_ext};
        end
    end

    // command needs no distinct path: a summary folds in like a row
    logic unused_cmd;
    assign unused_cmd = s_axis_tuser;

`include "typed_running_min_max_core_assert.svh"
    `TRMM_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, adv && r_iv && r_ilast,
        !r_seen && r_cnt == '0, "group state not cleared after last beat")
    `TRMM_ASSERT_IMPL(a_seen_count, i_clk, i_rst_n, r_seen == (r_cnt != '0),
        "seen flag disagrees with count")
    `TRMM_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_ov && !m_axis_tready,
        r_ov && $stable(r_odata), "result dropped under stall")
endmodule

// File: verif/typed_running_min_max_core_checker.sv
module typed_running_min_max_core_checker
    import trmm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxBits-1:0]  i_cfg_idx,
    input  logic [CfgDataBits-1:0] i_cfg_data,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [87:0]            i_s_tdata,
    input  logic                   i_s_tuser,
    input  logic                   i_s_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [103:0]           i_m_tdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_value      value;
        logic [15:0] row;
        logic        has_value;
        logic [15:0] count;
    } t_group_result;

    t_group_result      group_results_q[$];
    logic [TypeBits-1:0] cur_type;
    logic               cur_min;
    t_value             run_extreme;
    logic [15:0]        run_row;
    logic               run_seen;
    logic [15:0]        run_count;

    assign o_pending = group_results_q.size();

    // Order key of an IEEE value: NaN flagged, both zeros folded together
    function automatic t_value ieee_key(input t_value x, input bit dbl, output bit nan);
        t_value key;
        if (dbl) begin
            nan = (x[62:52] == 11'h7FF) && (x[51:0] != 0);
            key = (x[62:0] == 0) ? 64'h8000_0000_0000_0000 :
                  x[63] ? ~x : (x | 64'h8000_0000_0000_0000);
        end else begin
            nan = (x[30:23] == 8'hFF) && (x[22:0] != 0);
            key = (x[30:0] == 0) ? 64'h8000_0000 :
                  x[31] ? {32'h0, ~x[31:0]} : {32'h0, x[31:0] | 32'h8000_0000};
        end
        return key;
    endfunction

    // True when a comes strictly ahead of b in the selected order
    function automatic bit ranks_ahead(input t_value a, input t_value b);
        t_value ka;
        t_value kb;
        bit     na;
        bit     nb;
        int     w;
        w = (cur_type == TYPE_I8) ? 8 : (cur_type == TYPE_I16) ? 16 :
            (cur_type == TYPE_I32) ? 32 : 64;
        na = 0;
        nb = 0;
        case (cur_type)
            TYPE_I8, TYPE_I16, TYPE_I32, TYPE_I64: begin
                ka = (a << (64 - w)) ^ 64'h8000_0000_0000_0000;
                kb = (b << (64 - w)) ^ 64'h8000_0000_0000_0000;
            end
            TYPE_F32: begin
                ka = ieee_key(a, 1'b0, na);
                kb = ieee_key(b, 1'b0, nb);
            end
            TYPE_F64: begin
                ka = ieee_key(a, 1'b1, na);
                kb = ieee_key(b, 1'b1, nb);
            end
            default: begin
                ka = a & type_mask(cur_type);
                kb = b & type_mask(cur_type);
            end
        endcase
        if (na || nb) return 1'b0;
        return cur_min ? (ka < kb) : (ka > kb);
    endfunction

    task automatic report_mismatch(input string what, input t_value got, input t_value want);
        if (o_fail_count < 20)
            $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_value        bits;
        t_group_result res;
        if (!i_rst_n) begin
            cur_type    <= TYPE_I64;
            cur_min     <= 1'b0;
            run_extreme <= '0;
            run_row     <= '0;
            run_seen    <= 1'b0;
            run_count   <= '0;
            o_fail_count <= 0;
            o_results   <= 0;
            group_results_q.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_VALUE_TYPE) cur_type <= i_cfg_data;
                else                             cur_min  <= i_cfg_data[0];
            end
            // Fold an accepted input beat into the running state
            if (i_s_tvalid && i_s_tready) begin
                res.value     = run_extreme;
                res.row       = run_row;
                res.has_value = run_seen;
                res.count     = run_count;
                bits = i_s_tdata[63:0] & type_mask(cur_type);
                if (!i_s_tdata[64]) begin
                    if (!run_seen || ranks_ahead(bits, run_extreme)) begin
                        res.value = bits;
                        res.row   = i_s_tdata[80:65];
                    end
                    res.has_value = 1'b1;
                    if (res.count != 16'hFFFF) res.count++;
                end
                if (i_s_tlast) begin
                    group_results_q.push_back(res);
                    run_extreme <= '0;
                    run_row     <= '0;
                    run_seen    <= 1'b0;
                    run_count   <= '0;
                end else begin
                    run_extreme <= res.value;
                    run_row     <= res.row;
                    run_seen    <= res.has_value;
                    run_count   <= res.count;
                end
            end
            // Compare an accepted result beat with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                o_results <= o_results + 1;
                if (group_results_q.size() == 0) begin
                    report_mismatch("unexpected result", i_m_tdata[63:0], '0);
                end else begin
                    res = group_results_q.pop_front();
                    if (i_m_tdata[63:0] != res.value)
                        report_mismatch("extreme_value", i_m_tdata[63:0], res.value);
                    if (i_m_tdata[79:64] != res.row)
                        report_mismatch("extreme_row", i_m_tdata[79:64], res.row);
                    if (i_m_tdata[80] != res.has_value)
                        report_mismatch("has_value", i_m_tdata[80], res.has_value);
                    if (i_m_tdata[96:81] != res.count)
                        report_mismatch("value_count", i_m_tdata[96:81], res.count);
                end
            end
        end
    end
endmodule

// File: verif/typed_running_min_max_core_tb.sv
module typed_running_min_max_core_tb;
    import trmm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 5000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CfgIdxBits-1:0]  i_cfg_idx = '0;
    logic [CfgDataBits-1:0] i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [87:0]            s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [103:0]           m_axis_tdata;

    int     fail_count;
    int     pending;
    int     results;
    int     cycle_no = 0;
    int     quiet_cycles = 0;
    int     beats_sent = 0;
    int     phases = 0;
    bit     steady = 1'b0;
    t_value recent = '0;

    always #5 i_clk = ~i_clk;

    typed_running_min_max_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    typed_running_min_max_core_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    // Result side backpressure, with a stretch of constant ready
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= 300 && cycle_no < 600) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(99) >= 14);
    end

    // Stop the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("[typed_running_min_max_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold valid until the beat is taken; idle only before raising it
    task automatic send_beat(input bit cmd, input t_value val, input bit nul,
                             input logic [15:0] row, input bit lst);
        if (!steady && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 14);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= lst;
        s_axis_tdata  <= {7'b0, row, nul, val};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Wait out pending results plus the result pipeline before a write
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [TypeBits-1:0] vt, input bit mn);
        drain();
        write_reg(CFG_VALUE_TYPE, vt);
        write_reg(CFG_FIND_MIN, {3'b0, mn});
        phases++;
    endtask

    // Pick a value biased toward the edges of the current type
    function automatic t_value pick_value(input logic [TypeBits-1:0] vt);
        t_value junk;
        junk = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return recent;
            1: return junk & ~type_mask(vt);
            2: return junk | type_mask(vt);
            3: return (vt == TYPE_F32) ? {junk[63:32], 1'b0, 8'hFF, junk[22:1], 1'b1} :
                                         {1'b0, 11'h7FF, junk[51:1], 1'b1};
            4: return (vt == TYPE_F32) ? {junk[63:32], junk[31], 8'hFF, 23'h0} :
                                         {junk[63], 11'h7FF, 52'h0};
            5: return (vt == TYPE_F32) ? {junk[63:32], junk[31], 31'h0} : {junk[63], 63'h0};
            6: return (type_mask(vt) >> 1) ^ (junk[0] ? ~64'h0 : 64'h0);
            default: return junk;
        endcase
    endfunction

    task automatic random_group(input logic [TypeBits-1:0] vt);
        int     len;
        t_value v;
        len = $urandom_range(6);
        for (int k = 0; k <= len; k++) begin
            v = pick_value(vt);
            recent = v;
            send_beat(1'($urandom_range(1)), v, $urandom_range(99) < 15,
                      16'($urandom_range(16'hFFFF)), k == len);
        end
    endtask

    initial begin
        logic [TypeBits-1:0] vt;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset mode is int64 maximum
        send_beat(1'b0, 64'h8000_0000_0000_0000, 1'b0, 16'h0000, 1'b0);
        send_beat(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 16'hFFFF, 1'b0);
        send_beat(1'b0, 64'h0, 1'b1, 16'h1234, 1'b1);
        send_beat(1'b0, 64'h5, 1'b1, 16'h0001, 1'b1);
        send_beat(1'b1, 64'h5, 1'b0, 16'h0002, 1'b0);
        send_beat(1'b0, 64'h5, 1'b0, 16'h0003, 1'b1);
        // NaN first stays; signed zeros tie
        set_mode(TYPE_F32, 1'b1);
        send_beat(1'b0, 64'h7FC0_0000, 1'b0, 16'h0010, 1'b0);
        send_beat(1'b0, 64'h3F80_0000, 1'b0, 16'h0011, 1'b1);
        send_beat(1'b0, 64'h8000_0000, 1'b0, 16'h0012, 1'b0);
        send_beat(1'b0, 64'h0000_0000, 1'b0, 16'h0013, 1'b0);
        send_beat(1'b0, 64'h7FC0_0000, 1'b0, 16'h0014, 1'b1);
        set_mode(TYPE_F64, 1'b0);
        send_beat(1'b1, 64'hFFF0_0000_0000_0000, 1'b0, 16'h0020, 1'b0);
        send_beat(1'b0, 64'h7FF8_0000_0000_0001, 1'b0, 16'h0021, 1'b0);
        send_beat(1'b0, 64'h7FF0_0000_0000_0000, 1'b0, 16'h0022, 1'b1);
        // Type switched in the middle of a group
        set_mode(TYPE_U8, 1'b0);
        send_beat(1'b0, 64'hFFFF_FFFF_FFFF_FF80, 1'b0, 16'h0030, 1'b0);
        set_mode(TYPE_I8, 1'b0);
        send_beat(1'b0, 64'h7F, 1'b0, 16'h0031, 1'b0);
        send_beat(1'b0, 64'h01, 1'b0, 16'h0032, 1'b1);
        set_mode(4'd15, 1'b1);
        send_beat(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'h0040, 1'b0);
        send_beat(1'b0, 64'h0, 1'b0, 16'h0041, 1'b1);

        // Random groups across every type and both orders
        for (int p = 0; p < 14; p++) begin
            vt = (p < 10) ? p[3:0] : 4'(10 + $urandom_range(5));
            set_mode(vt, p[0]);
            steady = (p == 5 || p == 6);
            while (beats_sent < 32 * (p + 1)) random_group(vt);
            steady = 1'b0;
        end

        drain();
        $display("Checked %0d results from %0d input beats over %0d register settings,",
                 results, beats_sent, phases + 1);
        $display("covering all value types, min and max, nulls, NaNs, zeros and summaries.");
        if (fail_count == 0 && pending == 0) begin
            $display("[typed_running_min_max_core] OK");
        end else begin
            $display("[typed_running_min_max_core] ERROR");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/trmm_pkg.sv
hw/rtl/trmm_compare.sv
hw/rtl/typed_running_min_max_core.sv
verif/typed_running_min_max_core_checker.sv
verif/typed_running_min_max_core_tb.sv
